>>> src/skfc_pkg.sv
// Package for the sorted key frequency counter.
// Holds the controller state type, the cell control group and fixed field widths.
// No dependencies.
package skfc_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_OUT_W = 16;
    localparam int TDATA_W   = 48;

    typedef enum logic {
        ST_ACCEPT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             absorb;
        logic             shift;
        logic             room;
        logic             hit;
        logic [KEY_W-1:0] key;
    } t_cell_ctrl;

endpackage

>>> src/skfc_cell.sv
// One cell of the sorted key chain: holds one key, its count and a valid bit.
// Depends on skfc_pkg for the control group and key width.
module skfc_cell #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skfc_pkg::t_cell_ctrl          i_ctrl,
    input  logic                          i_prev_less,
    input  logic                          i_prev_valid,
    input  logic [skfc_pkg::KEY_W-1:0]    i_prev_key,
    input  logic [COUNT_BITS-1:0]         i_prev_cnt,
    input  logic                          i_next_valid,
    input  logic [skfc_pkg::KEY_W-1:0]    i_next_key,
    input  logic [COUNT_BITS-1:0]         i_next_cnt,
    output logic                          o_less,
    output logic                          o_match,
    output logic                          o_valid,
    output logic [skfc_pkg::KEY_W-1:0]    o_key,
    output logic [COUNT_BITS-1:0]         o_cnt
);
    import skfc_pkg::*;

    logic                  r_valid;
    logic [KEY_W-1:0]      r_key;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  n_valid;
    logic [KEY_W-1:0]      n_key;
    logic [COUNT_BITS-1:0] n_cnt;

    assign o_less  = r_valid && ($signed(r_key) < $signed(i_ctrl.key));
    assign o_match = r_valid && (r_key == i_ctrl.key);
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_cnt   = r_cnt;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_cnt   = r_cnt;
        if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
            n_cnt   = i_next_cnt;
        end else if (i_ctrl.absorb) begin
            if (i_ctrl.hit) begin
                if (o_match && (r_cnt != {COUNT_BITS{1'b1}})) begin
                    n_cnt = r_cnt + COUNT_BITS'(1);
                end
            end else if (i_ctrl.room && !o_less) begin
                if (i_prev_less) begin
                    n_valid = 1'b1;
                    n_key   = i_ctrl.key;
                    n_cnt   = COUNT_BITS'(1);
                end else begin
                    n_valid = i_prev_valid;
                    n_key   = i_prev_key;
                    n_cnt   = i_prev_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_cnt <= n_cnt;
    end

endmodule

>>> src/sorted_key_frequency_counter.sv
// A key is matched or inserted in the cycle it is accepted, one key per cycle while accepting;
// an unmatched key that finds the table full is dropped and sets the overflow flag.
// After a key with tlast, entries stream out from the head of the cell chain, one per cycle
// while the sink is ready. No key is accepted while entries are being emitted.
// Reset is synchronous and active low; it empties the chain and clears the overflow flag.
// Depends on skfc_pkg and skfc_cell.
module sorted_key_frequency_counter #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [skfc_pkg::KEY_W-1:0]       s_axis_tdata,  // [31:0] sample_key
    input  logic                             s_axis_tlast,  // run_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [skfc_pkg::TDATA_W-1:0]     m_axis_tdata,  // [31:0] entry_key, [47:32] entry_count
    output logic                             m_axis_tlast,  // final_entry
    output logic [0:0]                       m_axis_tuser   // [0] keys_dropped
);
    import skfc_pkg::*;

    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    t_state                r_state;
    t_state                n_state;
    logic [UW-1:0]         r_used;
    logic [UW-1:0]         n_used;
    logic                  r_ovf;
    logic                  n_ovf;
    t_cell_ctrl            w_ctrl;

    logic                  w_less  [TABLE_ENTRIES];
    logic                  w_match [TABLE_ENTRIES];
    logic                  w_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]      w_key   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] w_cnt   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_match_vec;
    logic [CNT_OUT_W-1:0]  w_cnt_out;
    logic                  w_in_xfer;
    logic                  w_out_xfer;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            assign w_match_vec[g] = w_match[g];
            if (g == 0) begin : g_head
                skfc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctrl       (w_ctrl),
                    .i_prev_less  (1'b1),
                    .i_prev_valid (1'b0),
                    .i_prev_key   ({KEY_W{1'b0}}),
                    .i_prev_cnt   ({COUNT_BITS{1'b0}}),
                    .i_next_valid ((TABLE_ENTRIES > 1) ? w_valid[(TABLE_ENTRIES > 1) ? 1 : 0]
                                                       : 1'b0),
                    .i_next_key   (w_key[(TABLE_ENTRIES > 1) ? 1 : 0]),
                    .i_next_cnt   (w_cnt[(TABLE_ENTRIES > 1) ? 1 : 0]),
                    .o_less       (w_less[g]),
                    .o_match      (w_match[g]),
                    .o_valid      (w_valid[g]),
                    .o_key        (w_key[g]),
                    .o_cnt        (w_cnt[g])
                );
            end else if (g == TABLE_ENTRIES - 1) begin : g_tail
                skfc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctrl       (w_ctrl),
                    .i_prev_less  (w_less[g-1]),
                    .i_prev_valid (w_valid[g-1]),
                    .i_prev_key   (w_key[g-1]),
                    .i_prev_cnt   (w_cnt[g-1]),
                    .i_next_valid (1'b0),
                    .i_next_key   ({KEY_W{1'b0}}),
                    .i_next_cnt   ({COUNT_BITS{1'b0}}),
                    .o_less       (w_less[g]),
                    .o_match      (w_match[g]),
                    .o_valid      (w_valid[g]),
                    .o_key        (w_key[g]),
                    .o_cnt        (w_cnt[g])
                );
            end else begin : g_mid
                skfc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctrl       (w_ctrl),
                    .i_prev_less  (w_less[g-1]),
                    .i_prev_valid (w_valid[g-1]),
                    .i_prev_key   (w_key[g-1]),
                    .i_prev_cnt   (w_cnt[g-1]),
                    .i_next_valid (w_valid[g+1]),
                    .i_next_key   (w_key[g+1]),
                    .i_next_cnt   (w_cnt[g+1]),
                    .o_less       (w_less[g]),
                    .o_match      (w_match[g]),
                    .o_valid      (w_valid[g]),
                    .o_key        (w_key[g]),
                    .o_cnt        (w_cnt[g])
                );
            end
        end

        if (COUNT_BITS > CNT_OUT_W) begin : g_sat
            assign w_cnt_out = (|w_cnt[0][COUNT_BITS-1:CNT_OUT_W]) ? {CNT_OUT_W{1'b1}}
                                                                   : w_cnt[0][CNT_OUT_W-1:0];
        end else begin : g_ext
            assign w_cnt_out = CNT_OUT_W'(w_cnt[0]);
        end
    endgenerate

    assign s_axis_tready = (r_state == ST_ACCEPT);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign w_out_xfer    = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {w_cnt_out, w_key[0]};
    assign m_axis_tlast  = (r_used == UW'(1));
    assign m_axis_tuser  = r_ovf;

    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_ovf         = r_ovf;
        w_ctrl.absorb = w_in_xfer;
        w_ctrl.shift  = w_out_xfer;
        w_ctrl.room   = (r_used < UW'(TABLE_ENTRIES));
        w_ctrl.hit    = |w_match_vec;
        w_ctrl.key    = s_axis_tdata;
        unique case (r_state)
            ST_ACCEPT: begin
                if (w_in_xfer) begin
                    if (!w_ctrl.hit) begin
                        if (w_ctrl.room) begin
                            n_used = r_used + UW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    n_used = r_used - UW'(1);
                    if (m_axis_tlast) begin
                        n_state = ST_ACCEPT;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_used  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ovf   <= n_ovf;
        end
    end

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_used != '0) && w_valid[0])
        else $error("Emission with an empty chain.");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_ENTRIES))
        else $error("Entry count exceeds the table size.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && m_axis_tlast) |=> (r_used == '0) && !r_ovf && !w_valid[0])
        else $error("Chain not cleared after the final transaction.");

    a_tail_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used < UW'(TABLE_ENTRIES)) |-> !w_valid[TABLE_ENTRIES-1])
        else $error("Tail cell valid while the table has room.");

    a_dup_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> $onehot0(w_match_vec))
        else $error("Key stored in more than one cell.");

endmodule
